// ----- src/ptt_pkg.sv -----
package ptt_pkg;

  localparam int MAX_TIMERS_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int NF_W           = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_CREATED  = 3'd0,
    K_REJECTED = 3'd1,
    K_DELETED  = 3'd2,
    K_NOTFOUND = 3'd3,
    K_FIRED    = 3'd4,
    K_NONEDUE  = 3'd5,
    K_EMPTY    = 3'd6,
    K_CLEARED  = 3'd7
  } kind_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] period;
    logic [31:0] last_fire;
    logic [31:0] param;
  } entry_t;

  typedef struct packed {
    logic rot;
    logic drop;
    logic load;
  } ctl_t;

  typedef struct packed {
    logic shift;
    logic wrap;
    logic load;
  } cell_ctl_t;

endpackage

// ----- src/ptt_cell.sv -----
module ptt_cell (
  input  logic               clk,
  input  ptt_pkg::cell_ctl_t ctl,
  input  ptt_pkg::entry_t    right,
  input  ptt_pkg::entry_t    head,
  input  ptt_pkg::entry_t    new_e,
  output ptt_pkg::entry_t    q
);

  ptt_pkg::entry_t ent_r;
  ptt_pkg::entry_t ent_nxt;

  always_comb begin
    priority if (ctl.load) begin
      ent_nxt = new_e;
    end else if (ctl.wrap) begin
      ent_nxt = head;
    end else if (ctl.shift) begin
      ent_nxt = right;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign q = ent_r;

endmodule

// ----- src/ptt_ctrl.sv -----
module ptt_ctrl #(
  parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF,
  parameter int CW         = $clog2(MAX_TIMERS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  ptt_pkg::cmd_t         cmd,
  input  logic [31:0]           now_ms,
  input  logic [31:0]           period_ms,
  input  logic signed [31:0]    user_param,
  input  logic [31:0]           target_id,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output ptt_pkg::kind_t        kind,
  output logic [31:0]           timer_id,
  output logic signed [31:0]    fired_param,
  output logic                  last,
  input  ptt_pkg::entry_t       head,
  output ptt_pkg::entry_t       head_new,
  output ptt_pkg::entry_t       new_e,
  output ptt_pkg::ctl_t         ctl,
  output logic [CW-1:0]         count
);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t                     state_r, state_nxt;
  logic                       op_tick_r, op_tick_nxt;
  logic [31:0]                now_r, now_nxt;
  logic [31:0]                tgt_r, tgt_nxt;
  logic [CW-1:0]              k_r, k_nxt;
  logic [CW-1:0]              len_r, len_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic                       found_r, found_nxt;
  logic [ptt_pkg::NF_W-1:0]   nfired_r, nfired_nxt;
  logic                       pend_v_r, pend_v_nxt;
  logic [31:0]                pend_id_r, pend_id_nxt;
  logic [31:0]                pend_param_r, pend_param_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ptt_pkg::kind_t             out_kind_r, out_kind_nxt;
  logic [31:0]                out_id_r, out_id_nxt;
  logic [31:0]                out_param_r, out_param_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_free;
  logic                       due;
  logic                       match;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign due       = ((now_r - head.last_fire) >= head.period) &&
                     (nfired_r < ptt_pkg::NF_W'(ptt_pkg::MAX_RESULTS));
  assign match     = (head.id == tgt_r) && !found_r;

  always_comb begin
    new_e.id        = now_ms;
    new_e.period    = period_ms;
    new_e.last_fire = now_ms;
    new_e.param     = user_param;
    head_new        = head;
    if (op_tick_r && due) begin
      head_new.last_fire = now_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_tick_nxt    = op_tick_r;
    now_nxt        = now_r;
    tgt_nxt        = tgt_r;
    k_nxt          = k_r;
    len_nxt        = len_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    nfired_nxt     = nfired_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    pend_param_nxt = pend_param_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_param_nxt  = out_param_r;
    out_last_nxt   = out_last_r;
    ctl            = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          now_nxt     = now_ms;
          tgt_nxt     = target_id;
          op_tick_nxt = (cmd == ptt_pkg::CMD_TICK);
          k_nxt       = '0;
          len_nxt     = count_r;
          found_nxt   = 1'b0;
          nfired_nxt  = '0;
          pend_v_nxt  = 1'b0;
          out_id_nxt    = '0;
          out_param_nxt = '0;
          out_last_nxt  = 1'b1;
          unique case (cmd)
            ptt_pkg::CMD_CREATE: begin
              out_valid_nxt = 1'b1;
              if (period_ms == '0 || count_r == CW'(MAX_TIMERS)) begin
                out_kind_nxt = ptt_pkg::K_REJECTED;
              end else begin
                ctl.load     = 1'b1;
                count_nxt    = count_r + CW'(1);
                out_kind_nxt = ptt_pkg::K_CREATED;
                out_id_nxt   = now_ms;
              end
            end
            ptt_pkg::CMD_DELETE: begin
              state_nxt = ST_WALK;
            end
            ptt_pkg::CMD_TICK: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = ptt_pkg::K_EMPTY;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            ptt_pkg::CMD_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = ptt_pkg::K_CLEARED;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (k_r != len_r) begin
          if (op_tick_r) begin
            if (!due) begin
              ctl.rot = 1'b1;
              k_nxt   = k_r + CW'(1);
            end else if (!pend_v_r || out_free) begin
              ctl.rot = 1'b1;
              k_nxt   = k_r + CW'(1);
              if (pend_v_r) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = ptt_pkg::K_FIRED;
                out_id_nxt    = pend_id_r;
                out_param_nxt = pend_param_r;
                out_last_nxt  = 1'b0;
              end
              pend_v_nxt     = 1'b1;
              pend_id_nxt    = head.id;
              pend_param_nxt = head.param;
              nfired_nxt     = nfired_r + ptt_pkg::NF_W'(1);
            end
          end else begin
            ctl.rot = 1'b1;
            k_nxt   = k_r + CW'(1);
            if (match) begin
              ctl.drop  = 1'b1;
              found_nxt = 1'b1;
              count_nxt = count_r - CW'(1);
            end
          end
        end else if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_id_nxt    = '0;
          out_param_nxt = '0;
          pend_v_nxt    = 1'b0;
          if (op_tick_r) begin
            if (pend_v_r) begin
              out_kind_nxt  = ptt_pkg::K_FIRED;
              out_id_nxt    = pend_id_r;
              out_param_nxt = pend_param_r;
            end else begin
              out_kind_nxt = ptt_pkg::K_NONEDUE;
            end
          end else if (found_r) begin
            out_kind_nxt = ptt_pkg::K_DELETED;
            out_id_nxt   = tgt_r;
          end else begin
            out_kind_nxt = ptt_pkg::K_NOTFOUND;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
    op_tick_r    <= op_tick_nxt;
    now_r        <= now_nxt;
    tgt_r        <= tgt_nxt;
    k_r          <= k_nxt;
    len_r        <= len_nxt;
    found_r      <= found_nxt;
    nfired_r     <= nfired_nxt;
    pend_id_r    <= pend_id_nxt;
    pend_param_r <= pend_param_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_param_r  <= out_param_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid  = out_valid_r;
  assign kind        = out_kind_r;
  assign timer_id    = out_id_r;
  assign fired_param = out_param_r;
  assign last        = out_last_r;
  assign count       = count_r;

endmodule

// ----- src/periodic_timer_table.sv -----
// Periodic timer table: up to MAX_TIMERS timers held in a row of cells, in
// creation order.
// Input channel in_*: in_tuser carries the command (create, delete by id,
// tick, clear); in_tdata carries the time, period, user value and target id.
// Result channel out_*: out_tuser the result kind, out_tdata the timer id and
// parameter, out_tlast on the final result of each input item.
// Create, clear and a tick on an empty table give their single result in the
// cycle after the item is accepted.
// Delete and tick rotate the cell row once around the live entries, one
// entry per cycle while no tick waits on the receiver, checking the entry
// at the head cell.
// One item is in work at a time; the next is accepted once the final result
// sits in the output register and that register can be refilled.
// A tick reports at most 16 firings; each fired result is held back until
// the next is found, so that the last one can carry out_tlast.
// When out_tready is low the rotation halts at the next firing and resumes
// as results are taken; nothing is dropped.
// Reset empties the table and clears the output; the cells keep no reset.
module periodic_timer_table #(
  parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // now_ms, period_ms, user_param, target_id
  input  logic [1:0]   in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // timer_id, fired_param
  output logic [2:0]   out_tuser,  // kind
  output logic         out_tlast
);

  localparam int CW = $clog2(MAX_TIMERS + 1);

  ptt_pkg::entry_t   ent [MAX_TIMERS];
  ptt_pkg::entry_t   head_new;
  ptt_pkg::entry_t   new_e;
  ptt_pkg::ctl_t     ctl;
  ptt_pkg::kind_t    kind;
  logic [CW-1:0]     count;
  logic [31:0]       timer_id;
  logic signed [31:0] fired_param;

  ptt_ctrl #(
    .MAX_TIMERS (MAX_TIMERS),
    .CW         (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .cmd         (ptt_pkg::cmd_t'(in_tuser)),
    .now_ms      (in_tdata[31:0]),
    .period_ms   (in_tdata[63:32]),
    .user_param  (in_tdata[95:64]),
    .target_id   (in_tdata[127:96]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .kind        (kind),
    .timer_id    (timer_id),
    .fired_param (fired_param),
    .last        (out_tlast),
    .head        (ent[0]),
    .head_new    (head_new),
    .new_e       (new_e),
    .ctl         (ctl),
    .count       (count)
  );

  for (genvar j = 0; j < MAX_TIMERS; j++) begin : g_cell
    ptt_pkg::cell_ctl_t cctl;
    ptt_pkg::entry_t    right;

    assign cctl.shift = ctl.rot && (CW'(j + 1) < count);
    assign cctl.wrap  = ctl.rot && !ctl.drop && (CW'(j + 1) == count);
    assign cctl.load  = ctl.load && (CW'(j) == count);

    if (j == MAX_TIMERS - 1) begin : g_tail
      assign right = ent[0];
    end else begin : g_mid
      assign right = ent[j + 1];
    end

    ptt_cell u_cell (
      .clk   (clk),
      .ctl   (cctl),
      .right (right),
      .head  (head_new),
      .new_e (new_e),
      .q     (ent[j])
    );
  end

  assign out_tdata = {fired_param, timer_id};
  assign out_tuser = kind;

endmodule

// ----- src/ptt_checker.sv -----
module ptt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ptt_pkg::K_FIRED |-> out_tlast)
    else $error("single result without last");

  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ptt_pkg::K_REJECTED || out_tuser == ptt_pkg::K_NOTFOUND ||
      out_tuser == ptt_pkg::K_NONEDUE || out_tuser == ptt_pkg::K_EMPTY ||
      out_tuser == ptt_pkg::K_CLEARED) |-> out_tdata == '0)
    else $error("nonzero data on status result");

  a_create_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ptt_pkg::CMD_CREATE |=>
      out_tvalid && (out_tuser == ptt_pkg::K_CREATED || out_tuser == ptt_pkg::K_REJECTED))
    else $error("create result missing");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- tb/tb_periodic_timer_table.sv -----
module tb_periodic_timer_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam int TABLE_DEPTH  = MAX_TIMERS_DEF;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 380;
  localparam int CALM_ITEMS   = 60;

  typedef struct {
    kind_t       kind;
    logic [31:0] id;
    logic [31:0] param;
    logic        last;
  } timer_result_t;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] now;
    logic [31:0] period;
    logic [31:0] param;
    logic [31:0] target;
    bit          typed;
    kind_t       kind;
    logic [31:0] id;
  } directed_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // now_ms, period_ms, user_param, target_id
  logic [1:0]   in_tuser = '0;   // cmd
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;       // timer_id, fired_param
  logic [2:0]   out_tuser;       // kind
  logic         out_tlast;

  logic [31:0] tt_id     [TABLE_DEPTH];
  logic [31:0] tt_period [TABLE_DEPTH];
  logic [31:0] tt_last   [TABLE_DEPTH];
  logic [31:0] tt_param  [TABLE_DEPTH];
  int          tt_count = 0;

  timer_result_t pending_results[$];
  directed_row_t directed_rows [21];
  int mismatches   = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;
  bit in_idle_en   = 1'b0;
  bit out_stall_en = 1'b0;

  periodic_timer_table #(.MAX_TIMERS(TABLE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic append_result(ref timer_result_t q[$], input timer_result_t r);
    q.insert(q.size(), r);
  endtask

  task automatic predict_timer_results(input cmd_t c, input logic [31:0] now,
                                       input logic [31:0] period, input logic [31:0] prm,
                                       input logic [31:0] target,
                                       ref timer_result_t res[$]);
    int          hit;
    logic [31:0] age;
    res.delete();
    case (c)
      CMD_CREATE: begin
        if (period == 32'd0 || tt_count >= TABLE_DEPTH) begin
          append_result(res, '{K_REJECTED, 32'd0, 32'd0, 1'b0});
        end else begin
          tt_id[tt_count]     = now;
          tt_period[tt_count] = period;
          tt_last[tt_count]   = now;
          tt_param[tt_count]  = prm;
          tt_count++;
          append_result(res, '{K_CREATED, now, 32'd0, 1'b0});
        end
      end
      CMD_DELETE: begin
        hit = -1;
        for (int i = 0; i < tt_count; i++)
          if (hit < 0 && tt_id[i] == target) hit = i;
        if (hit >= 0) begin
          for (int j = hit; j + 1 < tt_count; j++) begin
            tt_id[j]     = tt_id[j + 1];
            tt_period[j] = tt_period[j + 1];
            tt_last[j]   = tt_last[j + 1];
            tt_param[j]  = tt_param[j + 1];
          end
          tt_count--;
          append_result(res, '{K_DELETED, target, 32'd0, 1'b0});
        end else begin
          append_result(res, '{K_NOTFOUND, 32'd0, 32'd0, 1'b0});
        end
      end
      CMD_TICK: begin
        if (tt_count == 0) begin
          append_result(res, '{K_EMPTY, 32'd0, 32'd0, 1'b0});
        end else begin
          for (int i = 0; i < tt_count && res.size() < MAX_RESULTS; i++) begin
            age = now - tt_last[i];
            if (age >= tt_period[i]) begin
              tt_last[i] = now;
              append_result(res, '{K_FIRED, tt_id[i], tt_param[i], 1'b0});
            end
          end
          if (res.size() == 0) append_result(res, '{K_NONEDUE, 32'd0, 32'd0, 1'b0});
        end
      end
      default: begin
        tt_count = 0;
        append_result(res, '{K_CLEARED, 32'd0, 32'd0, 1'b0});
      end
    endcase
    res[res.size() - 1].last = 1'b1;
  endtask

  task automatic send_item(input cmd_t c, input logic [31:0] now, input logic [31:0] period,
                           input logic [31:0] prm, input logic [31:0] target,
                           input bit typed = 1'b0, input kind_t tk = K_CREATED,
                           input logic [31:0] tid = 32'd0);
    timer_result_t res[$];
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {target, prm, period, now};
    do @(posedge clk); while (!in_tready);
    predict_timer_results(c, now, period, prm, target, res);
    if (typed) append_result(pending_results, '{tk, tid, 32'd0, 1'b1});
    else foreach (res[k]) append_result(pending_results, res[k]);
    items_sent++;
    @(negedge clk);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (out_stall_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item kind %0d id %h param %h last %b", $time,
                     out_tuser, out_tdata[31:0], out_tdata[63:32], out_tlast);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.kind || out_tdata[31:0] !== want.id ||
              out_tdata[63:32] !== want.param || out_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: exp kind %0d id %h prm %h last %b, got kind %0d id %h prm %h last %b",
                       $time, want.kind, want.id, want.param, want.last,
                       out_tuser, out_tdata[31:0], out_tdata[63:32], out_tlast);
          end
        end
      end
    end
  end

  initial begin
    logic [31:0] clock_ms;
    int          seq_pick;
    int          op;
    int          stop_at;
    directed_rows = '{
      '{CMD_TICK,   32'd0, 32'd0, 32'd0, 32'd0, 1'b1, K_EMPTY, 32'd0},
      '{CMD_DELETE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, K_NOTFOUND, 32'd0},
      '{CMD_CLEAR,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        1'b1, K_CLEARED, 32'd0},
      '{CMD_CREATE, 32'd1234, 32'd0, 32'd1, 32'd0, 1'b1, K_REJECTED, 32'd0},
      '{CMD_CREATE, 32'd0, 32'd1, 32'h80000000, 32'd0, 1'b1, K_CREATED, 32'd0},
      '{CMD_CREATE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'd0,
        1'b1, K_CREATED, 32'hFFFFFFFF},
      '{CMD_CREATE, 32'd100, 32'd50, 32'hFFFFFFFF, 32'd0, 1'b1, K_CREATED, 32'd100},
      '{CMD_CREATE, 32'd100, 32'd10, 32'd5, 32'd0, 1'b1, K_CREATED, 32'd100},
      '{CMD_TICK,   32'd105, 32'd0, 32'd0, 32'd0, 1'b0, K_FIRED, 32'd0},
      '{CMD_TICK,   32'd105, 32'd0, 32'd0, 32'd0, 1'b0, K_FIRED, 32'd0},
      '{CMD_TICK,   32'd160, 32'd0, 32'd0, 32'd0, 1'b0, K_FIRED, 32'd0},
      '{CMD_DELETE, 32'd0, 32'd0, 32'd0, 32'd100, 1'b1, K_DELETED, 32'd100},
      '{CMD_DELETE, 32'd0, 32'd0, 32'd0, 32'd100, 1'b1, K_DELETED, 32'd100},
      '{CMD_DELETE, 32'd0, 32'd0, 32'd0, 32'd100, 1'b1, K_NOTFOUND, 32'd0},
      '{CMD_TICK,   32'hFFFFFFFE, 32'd0, 32'd0, 32'd0, 1'b0, K_FIRED, 32'd0},
      '{CMD_TICK,   32'd3, 32'd0, 32'd0, 32'd0, 1'b0, K_FIRED, 32'd0},
      '{CMD_DELETE, 32'd0, 32'd0, 32'd0, 32'hFFFFFFFF, 1'b1, K_DELETED, 32'hFFFFFFFF},
      '{CMD_CREATE, 32'd20, 32'h80000000, 32'd0, 32'd0, 1'b1, K_CREATED, 32'd20},
      '{CMD_CLEAR,  32'd0, 32'd0, 32'd0, 32'd0, 1'b1, K_CLEARED, 32'd0},
      '{CMD_TICK,   32'd50, 32'd0, 32'd0, 32'd0, 1'b1, K_EMPTY, 32'd0},
      '{CMD_CREATE, 32'd7, 32'd1, 32'd0, 32'd0, 1'b1, K_CREATED, 32'd7}
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    in_idle_en   = 1'b1;
    out_stall_en = 1'b1;

    foreach (directed_rows[r])
      send_item(directed_rows[r].cmd, directed_rows[r].now, directed_rows[r].period,
                directed_rows[r].param, directed_rows[r].target, directed_rows[r].typed,
                directed_rows[r].kind, directed_rows[r].id);

    clock_ms = 32'd1000;
    stop_at  = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if (items_sent >= stop_at - CALM_ITEMS) begin
        in_idle_en   = 1'b0;
        out_stall_en = 1'b0;
      end else begin
        in_idle_en   = $urandom_range(0, 3) != 0;
        out_stall_en = $urandom_range(0, 3) != 0;
      end
      seq_pick = $urandom_range(0, 19);
      if (seq_pick < 5) begin
        // fill the table, overflow it, then tick it and delete up to three entries
        send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
        while (tt_count < TABLE_DEPTH) begin
          clock_ms += $urandom_range(0, 3);
          send_item(CMD_CREATE, clock_ms, $urandom_range(1, 40), $urandom, $urandom);
        end
        repeat ($urandom_range(1, 2))
          send_item(CMD_CREATE, clock_ms, $urandom_range(1, 40), $urandom, $urandom);
        repeat ($urandom_range(1, 3)) begin
          clock_ms += $urandom_range(0, 60);
          send_item(CMD_TICK, clock_ms, $urandom, $urandom, $urandom);
        end
        repeat ($urandom_range(0, 3))
          send_item(CMD_DELETE, $urandom, $urandom, $urandom,
                    tt_id[$urandom_range(0, tt_count - 1)]);
      end else if (seq_pick < 17) begin
        repeat ($urandom_range(10, 30)) begin
          op = $urandom_range(0, 99);
          if (op < 35) begin
            if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
            case ($urandom_range(0, 9))
              0:       send_item(CMD_CREATE, clock_ms, 32'd0, $urandom, $urandom);
              1:       send_item(CMD_CREATE, clock_ms, $urandom, $urandom, $urandom);
              default: send_item(CMD_CREATE, clock_ms, $urandom_range(1, 150),
                                 $urandom, $urandom);
            endcase
          end else if (op < 55) begin
            if (tt_count > 0 && $urandom_range(0, 3) != 0)
              send_item(CMD_DELETE, $urandom, $urandom, $urandom,
                        tt_id[$urandom_range(0, tt_count - 1)]);
            else
              send_item(CMD_DELETE, $urandom, $urandom, $urandom, $urandom);
          end else if (op < 95) begin
            if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
            else clock_ms += $urandom_range(0, 60);
            send_item(CMD_TICK, clock_ms, $urandom, $urandom, $urandom);
          end else begin
            send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
          end
        end
      end else begin
        repeat ($urandom_range(3, 8))
          send_item(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * TABLE_DEPTH) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
